FILE: design/lgf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead goal finder package
// Shared command codes, field widths and the job record that travels from the
// front end through the job queue to the search engine.
// ----------------------------------------------------------------------------
package lgf_pkg;

   localparam int COORD_W     = 32;
   localparam int INDEX_W     = 10;
   localparam int DIST_W      = 31;
   localparam int CMD_W       = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [DIST_W-1:0] LOOKAHEAD_RESET = 31'd262144;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   // For an append a and b hold the point, for a query the robot position.
   typedef struct packed {
      cmd_type                    cmd;
      logic signed [COORD_W-1:0]  a;
      logic signed [COORD_W-1:0]  b;
   } job_type;

endpackage

FILE: design/lgf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead goal finder front end
// Accepts request items, decodes the command, drops unused command codes and
// hands each job to the job queue through one holding register.
// ----------------------------------------------------------------------------
module lgf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lgf_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [lgf_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [lgf_pkg::COORD_W-1:0] req_point_y,
   input  logic signed [lgf_pkg::COORD_W-1:0] req_robot_x,
   input  logic signed [lgf_pkg::COORD_W-1:0] req_robot_y,
   output logic                              job_valid,
   input  logic                              job_ready,
   output lgf_pkg::job_type                  job
);

   logic             hold_valid_ff, hold_valid_in;
   lgf_pkg::job_type hold_ff, hold_in;
   logic             take;

   assign req_ready = !hold_valid_ff || job_ready;
   assign take      = req_valid && req_ready;
   assign job_valid = hold_valid_ff;
   assign job       = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff && !job_ready;
      hold_in       = hold_ff;
      if (take) begin
         hold_in.cmd = lgf_pkg::cmd_type'(req_cmd);
         case (lgf_pkg::cmd_type'(req_cmd))
            lgf_pkg::CMD_CLEAR: begin
               hold_valid_in = 1'b1;
               hold_in.a     = req_point_x;
               hold_in.b     = req_point_y;
            end
            lgf_pkg::CMD_APPEND: begin
               hold_valid_in = 1'b1;
               hold_in.a     = req_point_x;
               hold_in.b     = req_point_y;
            end
            lgf_pkg::CMD_QUERY: begin
               hold_valid_in = 1'b1;
               hold_in.a     = req_robot_x;
               hold_in.b     = req_robot_y;
            end
            default: begin
               // The unused code is consumed and forgotten.
               hold_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

FILE: design/lgf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead goal finder job queue
// A short first-in first-out queue of jobs between the front end and the
// search engine, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module lgf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lgf_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output lgf_pkg::job_type pop_job
);

   localparam int CNT_W = lgf_pkg::QPTR_W + 1;

   lgf_pkg::job_type               ent_ff [lgf_pkg::QUEUE_DEPTH];
   logic [lgf_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           push, pop;

   assign push_ready = cnt_ff != CNT_W'(lgf_pkg::QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_job    = ent_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + lgf_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + lgf_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: design/lgf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead goal finder search engine
// Holds the point table and runs the two passes of a query through a
// four-stage distance pipeline, then loads the result register.
// ----------------------------------------------------------------------------
module lgf_back #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   output logic                               job_ready,
   input  lgf_pkg::job_type                   job,
   input  logic [lgf_pkg::DIST_W-1:0]         lookahead_dist,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [lgf_pkg::COORD_W-1:0] goal_x,
   output logic signed [lgf_pkg::COORD_W-1:0] goal_y,
   output logic [lgf_pkg::INDEX_W-1:0]        goal_pos,
   output logic                               status
);

   localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int CRD_W = lgf_pkg::COORD_W;
   localparam int SQ_W  = 2 * CRD_W;
   localparam int SUM_W = SQ_W + 1;
   localparam int LSQ_W = 2 * lgf_pkg::DIST_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_NEAR = 4'b0010,
      ST_WALK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   logic signed [CRD_W-1:0] mem_x [MAX_POINTS];
   logic signed [CRD_W-1:0] mem_y [MAX_POINTS];

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           issue_cnt_ff, issue_cnt_in;
   logic [CW-1:0]           recv_cnt_ff, recv_cnt_in;
   logic [AW-1:0]           walk_addr_ff, walk_addr_in;
   logic signed [CRD_W-1:0] robot_x_ff, robot_x_in, robot_y_ff, robot_y_in;
   logic [SUM_W-1:0]        best_ff, best_in;
   logic [AW-1:0]           nearest_ff, nearest_in;
   logic                    found_ff, found_in;
   logic [AW-1:0]           goal_idx_ff, goal_idx_in;
   logic signed [CRD_W-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [LSQ_W-1:0]        lsq_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CRD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [AW-1:0]           rsp_idx_ff, rsp_idx_in;
   logic                    rsp_status_ff, rsp_status_in;

   // Distance pipeline: read, absolute difference, square, sum.
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [AW-1:0]           s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic signed [CRD_W-1:0] rd_x_ff, rd_y_ff;
   logic signed [CRD_W-1:0] s2_x_ff, s2_y_ff, s3_x_ff, s3_y_ff, s4_x_ff, s4_y_ff;
   logic [CRD_W-1:0]        s2_dx_ff, s2_dy_ff;
   logic [SQ_W-1:0]         s3_sqx_ff, s3_sqy_ff;
   logic [SUM_W-1:0]        s4_dist_ff;

   logic [CRD_W:0]          diff_x, diff_y, mag_x, mag_y;
   logic                    out_free, pop, wr_en, rd_en, last_recv;
   logic [AW-1:0]           rd_addr;
   logic [AW+lgf_pkg::INDEX_W-1:0] idx_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_en     = (state_ff == ST_NEAR || state_ff == ST_WALK) &&
                      (issue_cnt_ff != count_ff);
   assign rd_addr   = (state_ff == ST_WALK) ? walk_addr_ff : issue_cnt_ff[AW-1:0];
   assign last_recv = s4_valid_ff && (recv_cnt_ff + CW'(1) == count_ff);

   always_comb begin
      pop = 1'b0;
      if (state_ff == ST_IDLE && job_valid) begin
         // An empty-table query answers at once and needs the result register.
         pop = !(job.cmd == lgf_pkg::CMD_QUERY && count_ff == '0) || out_free;
      end
   end
   assign job_ready = pop;
   assign wr_en     = pop && job.cmd == lgf_pkg::CMD_APPEND &&
                      count_ff != CW'(MAX_POINTS);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_cnt_in  = issue_cnt_ff;
      recv_cnt_in   = recv_cnt_ff;
      walk_addr_in  = walk_addr_ff;
      robot_x_in    = robot_x_ff;
      robot_y_in    = robot_y_ff;
      best_in       = best_ff;
      nearest_in    = nearest_ff;
      found_in      = found_ff;
      goal_idx_in   = goal_idx_ff;
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;

      if (rd_en) begin
         issue_cnt_in = issue_cnt_ff + CW'(1);
      end
      if (s4_valid_ff) begin
         recv_cnt_in = recv_cnt_ff + CW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (job.cmd)
                  lgf_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  lgf_pkg::CMD_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  lgf_pkg::CMD_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_x_in      = '0;
                        rsp_y_in      = '0;
                        rsp_idx_in    = '0;
                        rsp_status_in = 1'b1;
                     end else begin
                        robot_x_in   = job.a;
                        robot_y_in   = job.b;
                        issue_cnt_in = '0;
                        recv_cnt_in  = '0;
                        state_in     = ST_NEAR;
                     end
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_NEAR: begin
            if (s4_valid_ff && (recv_cnt_ff == '0 || s4_dist_ff < best_ff)) begin
               best_in    = s4_dist_ff;
               nearest_in = s4_idx_ff;
            end
            if (last_recv) begin
               walk_addr_in = nearest_in;
               issue_cnt_in = '0;
               recv_cnt_in  = '0;
               found_in     = 1'b0;
               state_in     = ST_WALK;
            end
         end
         ST_WALK: begin
            if (rd_en) begin
               walk_addr_in = (CW'(walk_addr_ff) + CW'(1) == count_ff) ?
                              '0 : walk_addr_ff + AW'(1);
            end
            // The first point beyond the lookahead circle becomes the final goal;
            // until then the goal follows each visited point.
            if (s4_valid_ff && !found_ff) begin
               goal_idx_in = s4_idx_ff;
               goal_x_in   = s4_x_ff;
               goal_y_in   = s4_y_ff;
               if (s4_dist_ff > SUM_W'(lsq_ff)) begin
                  found_in = 1'b1;
               end
            end
            if (last_recv) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = goal_x_ff;
               rsp_y_in      = goal_y_ff;
               rsp_idx_in    = goal_idx_ff;
               rsp_status_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_cnt_ff <= '0;
         recv_cnt_ff  <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_cnt_ff <= issue_cnt_in;
         recv_cnt_ff  <= recv_cnt_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= rd_en;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      walk_addr_ff  <= walk_addr_in;
      robot_x_ff    <= robot_x_in;
      robot_y_ff    <= robot_y_in;
      best_ff       <= best_in;
      nearest_ff    <= nearest_in;
      goal_idx_ff   <= goal_idx_in;
      goal_x_ff     <= goal_x_in;
      goal_y_ff     <= goal_y_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
      lsq_ff        <= LSQ_W'(lookahead_dist) * LSQ_W'(lookahead_dist);
   end

   // Point table, one write port for appends and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[count_ff[AW-1:0]] <= job.a;
         mem_y[count_ff[AW-1:0]] <= job.b;
      end
      if (rd_en) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
   end

   always_comb begin
      diff_x = {rd_x_ff[CRD_W-1], rd_x_ff} - {robot_x_ff[CRD_W-1], robot_x_ff};
      diff_y = {rd_y_ff[CRD_W-1], rd_y_ff} - {robot_y_ff[CRD_W-1], robot_y_ff};
      mag_x  = diff_x[CRD_W] ? (~diff_x + (CRD_W+1)'(1)) : diff_x;
      mag_y  = diff_y[CRD_W] ? (~diff_y + (CRD_W+1)'(1)) : diff_y;
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= rd_addr;
      s2_idx_ff  <= s1_idx_ff;
      s2_x_ff    <= rd_x_ff;
      s2_y_ff    <= rd_y_ff;
      s2_dx_ff   <= mag_x[CRD_W-1:0];
      s2_dy_ff   <= mag_y[CRD_W-1:0];
      s3_idx_ff  <= s2_idx_ff;
      s3_x_ff    <= s2_x_ff;
      s3_y_ff    <= s2_y_ff;
      s3_sqx_ff  <= SQ_W'(s2_dx_ff) * SQ_W'(s2_dx_ff);
      s3_sqy_ff  <= SQ_W'(s2_dy_ff) * SQ_W'(s2_dy_ff);
      s4_idx_ff  <= s3_idx_ff;
      s4_x_ff    <= s3_x_ff;
      s4_y_ff    <= s3_y_ff;
      s4_dist_ff <= SUM_W'(s3_sqx_ff) + SUM_W'(s3_sqy_ff);
   end

   assign idx_ext   = {{lgf_pkg::INDEX_W{1'b0}}, rsp_idx_ff};
   assign rsp_valid = rsp_valid_ff;
   assign goal_x    = rsp_x_ff;
   assign goal_y    = rsp_y_ff;
   assign goal_pos  = idx_ext[lgf_pkg::INDEX_W-1:0];
   assign status    = rsp_status_ff;

endmodule

FILE: design/lookahead_goal_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead goal finder
// Keeps a table of path points and answers goal queries with the first point
// beyond the lookahead distance, walking forward from the nearest point.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries command items: clear the table, append a point, or query
//          with a robot position. tuser holds the command code.
//   rsp_*  carries one result item per query and nothing for other commands.
//   csr_*  writes the lookahead distance; write it only while the block idles.
// Data path:
//   An item passes a front holding register and a two-entry job queue before
//   the search engine sees it. A query on N stored points runs two passes
//   through a four-stage distance pipeline fed by one memory read port; a
//   query on an empty table is answered without running the passes.
// Reset:
//   The point count goes to zero and the lookahead distance to 4.0 m; the
//   point memory is not cleared, as only entries below the count are read.
// Backpressure:
//   A result waits in the output register while rsp_tready is low; the front
//   end and queue keep taking items until the queue fills.
// ----------------------------------------------------------------------------
module lookahead_goal_finder #(
   parameter int MAX_POINTS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_x [31:0], point_y [63:32], robot_x [95:64], robot_y [127:96]
   input  logic [127:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // goal_x [31:0], goal_y [63:32], goal_pos [73:64], zero fill [79:74]
   output logic [79:0]  rsp_tdata,
   // status [0]
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [30:0]  csr_data
);

   localparam int CRD_W = lgf_pkg::COORD_W;

   logic                      front_valid, front_ready, job_valid, job_ready;
   lgf_pkg::job_type          front_job, job;
   logic [lgf_pkg::DIST_W-1:0] lookahead_ff;
   logic signed [CRD_W-1:0]   goal_x, goal_y;
   logic [lgf_pkg::INDEX_W-1:0] goal_pos;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lookahead_ff <= lgf_pkg::LOOKAHEAD_RESET;
      end else if (csr_valid) begin
         lookahead_ff <= csr_data;
      end
   end

   lgf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_point_x (req_tdata[CRD_W-1:0]),
      .req_point_y (req_tdata[2*CRD_W-1:CRD_W]),
      .req_robot_x (req_tdata[3*CRD_W-1:2*CRD_W]),
      .req_robot_y (req_tdata[4*CRD_W-1:3*CRD_W]),
      .job_valid   (front_valid),
      .job_ready   (front_ready),
      .job         (front_job)
   );

   lgf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_job    (job)
   );

   lgf_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job_ready      (job_ready),
      .job            (job),
      .lookahead_dist (lookahead_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .goal_x         (goal_x),
      .goal_y         (goal_y),
      .goal_pos       (goal_pos),
      .status         (rsp_tuser)
   );

   assign rsp_tdata = {6'b0, goal_pos, goal_y, goal_x};

endmodule

FILE: test/lookahead_goal_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead goal finder testbench
// Drives clear, append and query items with random idling on both streams and
// predicts every goal result from a table of its own. Directed tests cover
// an empty table, ties, wrap-around, the no-point-far-enough case, extreme
// coordinates and a long path sent without idling; random paths then run
// under several settings of the lookahead distance.
// ----------------------------------------------------------------------------
module lookahead_goal_finder_tb;

   localparam int COORD_W = lgf_pkg::COORD_W;
   localparam int INDEX_W = lgf_pkg::INDEX_W;
   localparam int DIST_W = lgf_pkg::DIST_W;
   localparam int CMD_W = lgf_pkg::CMD_W;
   localparam int MAX_POINTS = 1024;
   localparam int LONG_PATH = 40;
   localparam int PHASE_ITEMS = 32;
   localparam int IDLE_CYCLES = 32;
   localparam int HALF_METRE = 32768;
   localparam int ONE_METRE = 65536;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

   typedef struct {
      logic signed [COORD_W-1:0] gx;
      logic signed [COORD_W-1:0] gy;
      logic [INDEX_W-1:0]        gidx;
      logic                      stat;
   } goal_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [79:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [30:0]   csr_data = '0;

   // Predicted block state.
   logic signed [COORD_W-1:0] path_x [MAX_POINTS];
   logic signed [COORD_W-1:0] path_y [MAX_POINTS];
   int                        path_len = 0;
   logic [DIST_W-1:0]         look_dist = lgf_pkg::LOOKAHEAD_RESET;

   goal_type goal_queue [$];
   int       mismatch_count = 0;
   int       item_count = 0;
   bit       no_idle = 1'b0;
   int       cur_x = 0;
   int       cur_y = 0;

   lookahead_goal_finder #(
      .MAX_POINTS(MAX_POINTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 12);
   end

   // Exact squared distance; the sum of two squares can need all 65 bits.
   function automatic logic [64:0] dist_sq(
      input logic signed [COORD_W-1:0] px, py, rx, ry);
      logic [COORD_W:0] dx;
      logic [COORD_W:0] dy;
      dx = {px[COORD_W-1], px} - {rx[COORD_W-1], rx};
      dy = {py[COORD_W-1], py} - {ry[COORD_W-1], ry};
      if (dx[COORD_W]) dx = -dx;
      if (dy[COORD_W]) dy = -dy;
      return {32'd0, dx} * {32'd0, dx} + {32'd0, dy} * {32'd0, dy};
   endfunction

   function automatic goal_type find_goal(input logic signed [COORD_W-1:0] rx, ry);
      goal_type    res;
      logic [64:0] best;
      logic [64:0] d;
      logic [64:0] reach_sq;
      int          nearest;
      int          idx;
      res.gx = '0;
      res.gy = '0;
      res.gidx = '0;
      res.stat = 1'b1;
      if (path_len == 0) return res;
      nearest = 0;
      best = dist_sq(path_x[0], path_y[0], rx, ry);
      for (int i = 1; i < path_len; i++) begin
         d = dist_sq(path_x[i], path_y[i], rx, ry);
         if (d < best) begin
            best = d;
            nearest = i;
         end
      end
      reach_sq = {34'd0, look_dist};
      reach_sq = reach_sq * reach_sq;
      // Walk forward with wrap-around; if nothing lies beyond the lookahead
      // distance the walk ends on the point just before the nearest one.
      idx = nearest;
      for (int i = 0; i < path_len; i++) begin
         idx = (nearest + i) % path_len;
         if (dist_sq(path_x[idx], path_y[idx], rx, ry) > reach_sq) break;
      end
      res.gx = path_x[idx];
      res.gy = path_y[idx];
      res.gidx = idx[INDEX_W-1:0];
      res.stat = 1'b0;
      return res;
   endfunction

   function automatic void track_command(input logic [CMD_W-1:0] code,
                                         input logic signed [COORD_W-1:0] px, py, rx, ry);
      case (code)
         lgf_pkg::CMD_CLEAR: path_len = 0;
         lgf_pkg::CMD_APPEND: begin
            if (path_len < MAX_POINTS) begin
               path_x[path_len] = px;
               path_y[path_len] = py;
               path_len++;
            end
         end
         lgf_pkg::CMD_QUERY: goal_queue.insert(goal_queue.size(), find_goal(rx, ry));
         default: ;
      endcase
   endfunction

   function automatic int grid_step(input int span);
      int r;
      r = $urandom_range(0, 2 * span);
      return (r - span) * HALF_METRE;
   endfunction

   // All tasks below start and end at a falling edge.
   task automatic send_item(input logic [CMD_W-1:0] code,
                            input logic signed [COORD_W-1:0] px, py, rx, ry);
      while (!no_idle && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {ry, rx, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_command(code, px, py, rx, ry);
      item_count++;
      @(negedge clock);
   endtask

   task automatic clear_table();
      send_item(lgf_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic append_point(input logic signed [COORD_W-1:0] x, y);
      send_item(lgf_pkg::CMD_APPEND, x, y, $urandom, $urandom);
   endtask

   task automatic query_goal(input logic signed [COORD_W-1:0] x, y);
      send_item(lgf_pkg::CMD_QUERY, $urandom, $urandom, x, y);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (goal_queue.size() != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   // Only called once the block is idle.
   task automatic write_lookahead(input logic [DIST_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      look_dist = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic extend_path(input int count);
      repeat (count) begin
         if ($urandom_range(0, 11) == 0) begin
            append_point($urandom, $urandom);
         end else begin
            cur_x += grid_step(4);
            cur_y += grid_step(4);
            append_point(cur_x, cur_y);
         end
      end
   endtask

   task automatic query_near_path();
      int j;
      int pick;
      pick = $urandom_range(0, 9);
      if (path_len == 0 || pick == 0) begin
         query_goal($urandom, $urandom);
      end else begin
         j = $urandom_range(0, path_len - 1);
         if (pick == 1) query_goal(path_x[j], path_y[j]);
         else query_goal(path_x[j] + grid_step(6), path_y[j] + grid_step(6));
      end
   endtask

   task automatic test_empty_table();
      query_goal($urandom, $urandom);
      send_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
      clear_table();
      query_goal(COORD_MIN, COORD_MAX);
   endtask

   // Points one metre apart along x, lookahead 4.0 m.
   task automatic test_straight_path();
      clear_table();
      for (int i = 0; i < 8; i++) append_point(i * ONE_METRE, 0);
      query_goal(0, 0);
      // Halfway between the last two points: the tie goes to the lower index
      // and the walk wraps to the start of the table.
      query_goal(6 * ONE_METRE + HALF_METRE, 0);
      // From the middle no point lies beyond 4 m.
      query_goal(3 * ONE_METRE + HALF_METRE, 0);
   endtask

   task automatic test_extreme_points();
      clear_table();
      append_point(COORD_MIN, COORD_MIN);
      append_point(COORD_MAX, COORD_MAX);
      append_point(0, 0);
      append_point(COORD_MIN, COORD_MAX);
      query_goal(COORD_MAX, COORD_MAX);
      query_goal(COORD_MIN, COORD_MIN);
      wait_idle();
      write_lookahead(DIST_MAX);
      query_goal(COORD_MIN, COORD_MIN);
      wait_idle();
      write_lookahead('0);
      query_goal(0, 0);
   endtask

   // A long path and its first two queries go out with no idling on either stream.
   task automatic test_long_path();
      wait_idle();
      write_lookahead(DIST_W'(3 * ONE_METRE));
      no_idle = 1'b1;
      clear_table();
      cur_x = grid_step(64);
      cur_y = grid_step(64);
      extend_path(LONG_PATH);
      query_near_path();
      query_goal(path_x[path_len - 1], path_y[path_len - 1]);
      no_idle = 1'b0;
      wait_idle();
      query_near_path();
      clear_table();
      query_goal($urandom, $urandom);
   endtask

   task automatic test_random_paths();
      logic [DIST_W-1:0] setting;
      int                phase_end;
      int                pick;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: setting = '0;
            1: setting = DIST_W'(ONE_METRE);
            2: setting = DIST_MAX;
            3: setting = DIST_W'($urandom_range(0, 8 * ONE_METRE));
            4: setting = DIST_W'($urandom);
            default: setting = lgf_pkg::LOOKAHEAD_RESET;
         endcase
         wait_idle();
         write_lookahead(setting);
         phase_end = item_count + PHASE_ITEMS;
         while (item_count < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_item(CMD_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                         $urandom);
            end else if (pick < 22 || path_len == 0 || path_len >= 40) begin
               clear_table();
               cur_x = grid_step(128);
               cur_y = grid_step(128);
               extend_path($urandom_range(1, 16));
            end else if (pick < 40) begin
               extend_path($urandom_range(1, 4));
            end else begin
               query_near_path();
               if ($urandom_range(0, 14) == 0) wait_idle();
            end
         end
      end
   endtask

   task automatic compare_field(input string what, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      goal_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (goal_queue.size() == 0) begin
            $display("%0t: result with no query waiting, expected none, got %h %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = goal_queue.pop_front();
            compare_field("goal_x", want.gx, rsp_tdata[31:0]);
            compare_field("goal_y", want.gy, rsp_tdata[63:32]);
            compare_field("goal_pos", {22'd0, want.gidx}, {22'd0, rsp_tdata[73:64]});
            compare_field("status", {31'd0, want.stat}, {31'd0, rsp_tuser});
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_table();
      test_straight_path();
      test_extreme_points();
      test_long_path();
      test_random_paths();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: lookahead_goal_finder.f
design/lgf_pkg.sv
design/lgf_front.sv
design/lgf_queue.sv
design/lgf_back.sv
design/lookahead_goal_finder.sv
test/lookahead_goal_finder_tb.sv
